// File: hw/rtl/wcw_pkg.sv
// Package for the window challenge watchdog: event, mode and result codes,
// state, event and config structs, challenge constants.
// No dependencies.
package wcw_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned WordW = 32;

  localparam logic [WordW-1:0] MaskKey = 32'h5A5A_5A5A;
  localparam logic [WordW-1:0] LcgMul  = 32'd1103515245;
  localparam logic [WordW-1:0] LcgAdd  = 32'd12345;

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_REFRESH = 2'd1,
    KIND_CHAL    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    MODE_PLAIN  = 2'd0,
    MODE_WINDOW = 2'd1,
    MODE_CHAL   = 2'd2,
    MODE_SPARE  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_INACTIVE   = 3'd1,
    ST_EARLY      = 3'd2,
    ST_BAD_MODE   = 3'd3,
    ST_BAD_ANSWER = 3'd4
  } status_e;

  // Config register indexes
  localparam logic CfgMode   = 1'b0;
  localparam logic CfgWinMin = 1'b1;

  typedef struct packed {
    logic             active;
    logic [TimeW-1:0] last_time;
    logic [WordW-1:0] refresh_cnt;
    logic [WordW-1:0] early_cnt;
    logic [TimeW-1:0] max_intv;
    logic [WordW-1:0] challenge;
  } state_t;

  typedef struct packed {
    kind_e            kind;
    logic [TimeW-1:0] now_ms;
    logic [WordW-1:0] answer;
  } evt_t;

  typedef struct packed {
    mode_e            mode;
    logic [TimeW-1:0] win_min;
  } cfg_t;

endpackage

// File: hw/rtl/wcw_eval.sv
// Next-state evaluation for one watchdog event: refresh checks, window
// check, challenge verify and LCG step. Pure combinational.
// Depends on wcw_pkg.
module wcw_eval (
  input  wcw_pkg::cfg_t    cfg_i,
  input  wcw_pkg::state_t  state_i,
  input  wcw_pkg::evt_t    evt_i,
  output wcw_pkg::state_t  state_o,
  output wcw_pkg::status_e status_o
);

  logic [wcw_pkg::TimeW-1:0] gap;
  logic                      do_refresh;

  assign gap = evt_i.now_ms - state_i.last_time;

  always_comb begin
    state_o    = state_i;
    status_o   = wcw_pkg::ST_OK;
    do_refresh = 1'b0;

    unique case (evt_i.kind)
      wcw_pkg::KIND_START: begin
        state_o.active = 1'b1;
      end
      wcw_pkg::KIND_REFRESH: begin
        do_refresh = 1'b1;
      end
      wcw_pkg::KIND_CHAL: begin
        priority if (cfg_i.mode != wcw_pkg::MODE_CHAL) begin
          status_o = wcw_pkg::ST_BAD_MODE;
        end else if (evt_i.answer != (state_i.challenge ^ wcw_pkg::MaskKey)) begin
          status_o = wcw_pkg::ST_BAD_ANSWER;
        end else begin
          // Advance the challenge even if the refresh below is refused
          state_o.challenge = state_i.challenge * wcw_pkg::LcgMul + wcw_pkg::LcgAdd;
          do_refresh        = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (do_refresh) begin
      priority if (!state_i.active) begin
        status_o = wcw_pkg::ST_INACTIVE;
      end else if (cfg_i.mode == wcw_pkg::MODE_WINDOW && gap < cfg_i.win_min) begin
        status_o          = wcw_pkg::ST_EARLY;
        state_o.early_cnt = state_i.early_cnt + 32'd1;
      end else begin
        if (gap > state_i.max_intv) begin
          state_o.max_intv = gap;
        end
        state_o.last_time   = evt_i.now_ms;
        state_o.refresh_cnt = state_i.refresh_cnt + 32'd1;
      end
    end
  end

endmodule

// File: hw/rtl/window_challenge_watchdog_unit.sv
// Window challenge watchdog: an accepted item passes through the input
// register, then the state and result registers, before its result is valid.
// Throughput is one item per cycle; the input stalls only while both
// registers are full and the result is held. The state update is a single
// pass through wcw_eval, whose deepest path is the 32x32 challenge multiply.
// rst_ni clears the watchdog state, config registers and both valid flags.
// Depends on wcw_pkg and wcw_eval.
module window_challenge_watchdog_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_addr_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [63:0]  s_axis_tdata_i,   // now_ms[31:0], answer[63:32]
  input  logic [1:0]   s_axis_tuser_i,   // kind[1:0]
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // status[2:0], current_challenge[34:3], refreshes[66:35],
  // early_refreshes[98:67], longest_interval[130:99], zero[135:131]
  output logic [135:0] m_axis_tdata_o
);

  wcw_pkg::cfg_t    cfg_q;
  wcw_pkg::state_t  state_q, state_d;
  wcw_pkg::evt_t    evt_q;
  logic             evt_vld_q;
  logic             out_vld_q;
  wcw_pkg::status_e status_q, status_d;
  logic             advance;
  logic             s_fire;

  assign advance         = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = !evt_vld_q || advance;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        wcw_pkg::CfgMode:   cfg_q.mode    <= wcw_pkg::mode_e'(cfg_wdata_i[1:0]);
        wcw_pkg::CfgWinMin: cfg_q.win_min <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      evt_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      evt_q.kind   <= wcw_pkg::kind_e'(s_axis_tuser_i);
      evt_q.now_ms <= s_axis_tdata_i[31:0];
      evt_q.answer <= s_axis_tdata_i[63:32];
    end
  end

  wcw_eval u_eval (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .evt_i    (evt_q),
    .state_o  (state_d),
    .status_o (status_d)
  );

  // State and result register update together, so the state registers
  // always hold the snapshot that belongs to the item in the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '0;
      out_vld_q <= 1'b0;
      status_q  <= wcw_pkg::ST_OK;
    end else if (advance) begin
      out_vld_q <= evt_vld_q;
      if (evt_vld_q) begin
        state_q  <= state_d;
        status_q <= status_d;
      end
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {5'd0, state_q.max_intv, state_q.early_cnt,
                            state_q.refresh_cnt, state_q.challenge, status_q};

  // The watchdog is never disarmed
  a_active_stays : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(state_q.active))
    else $error("watchdog disarmed");

  // Refresh count moves only by one
  a_refresh_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.refresh_cnt != $past(state_q.refresh_cnt)) |->
    (state_q.refresh_cnt == $past(state_q.refresh_cnt) + 32'd1))
    else $error("refresh count jumped");

  // Early count changes only with an early result on the port
  a_early_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.early_cnt != $past(state_q.early_cnt)) |->
    (out_vld_q && status_q == wcw_pkg::ST_EARLY))
    else $error("early count moved without early status");

  // Input stalls only behind a stalled result
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without output backpressure");

endmodule

// File: tb/window_challenge_watchdog_unit_test.sv
`timescale 1ns / 100ps
// Self-checking bench for window_challenge_watchdog_unit: drives start, refresh, challenge and unused-kind items,
// predicts every result with a scoreboard class and checks the result port field by field.
// Depends on wcw_pkg and the watchdog RTL.
module window_challenge_watchdog_unit_test;
  import wcw_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned ChunkItems  = 78;

  typedef struct {
    status_e     status;
    logic [31:0] challenge;
    logic [31:0] refreshes;
    logic [31:0] early;
    logic [31:0] longest;
  } watch_result_t;

  // Tracks the watchdog state and the results still owed by the block.
  class watchdog_tracker;
    mode_e         mode;
    logic [31:0]   win_min;
    bit            armed;
    logic [31:0]   last_time;
    logic [31:0]   refresh_cnt;
    logic [31:0]   early_cnt;
    logic [31:0]   max_gap;
    logic [31:0]   challenge;
    watch_result_t owed_q[$];
    int            errors;

    function new();
      mode        = MODE_PLAIN;
      win_min     = '0;
      armed       = 1'b0;
      last_time   = '0;
      refresh_cnt = '0;
      early_cnt   = '0;
      max_gap     = '0;
      challenge   = '0;
      errors      = 0;
    endfunction

    function void set_reg(logic addr, logic [31:0] value);
      if (addr == CfgMode) begin
        mode = mode_e'(value[1:0]);
      end else begin
        win_min = value;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function status_e try_refresh(logic [31:0] now);
      logic [31:0] gap;
      if (!armed) return ST_INACTIVE;
      gap = now - last_time;
      if (mode == MODE_WINDOW && gap < win_min) begin
        early_cnt = early_cnt + 1;
        return ST_EARLY;
      end
      if (gap > max_gap) max_gap = gap;
      last_time   = now;
      refresh_cnt = refresh_cnt + 1;
      return ST_OK;
    endfunction

    function void log_event(kind_e kind, logic [31:0] now, logic [31:0] answer);
      watch_result_t want;
      status_e       status;
      status = ST_OK;
      case (kind)
        KIND_START: begin
          armed = 1'b1;
        end
        KIND_REFRESH: begin
          status = try_refresh(now);
        end
        KIND_CHAL: begin
          if (mode != MODE_CHAL) begin
            status = ST_BAD_MODE;
          end else if (answer != (challenge ^ MaskKey)) begin
            status = ST_BAD_ANSWER;
          end else begin
            // advance the challenge even if the refresh is refused
            challenge = challenge * LcgMul + LcgAdd;
            status    = try_refresh(now);
          end
        end
        default: begin
        end
      endcase
      want.status    = status;
      want.challenge = challenge;
      want.refreshes = refresh_cnt;
      want.early     = early_cnt;
      want.longest   = max_gap;
      owed_q.push_back(want);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%08h, got 0x%08h", field, want, got);
        errors++;
      end
    endfunction

    function void match_result(logic [135:0] data);
      watch_result_t want;
      if (owed_q.size() == 0) begin
        $error("result item with no event pending: 0x%034h", data);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      compare("status", want.status, data[2:0]);
      compare("current_challenge", want.challenge, data[34:3]);
      compare("refreshes", want.refreshes, data[66:35]);
      compare("early_refreshes", want.early, data[98:67]);
      compare("longest_interval", want.longest, data[130:99]);
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni          = 1'b0;
  logic          cfg_we_i        = 1'b0;
  logic          cfg_addr_i      = 1'b0;
  logic [31:0]   cfg_wdata_i     = '0;
  logic          s_axis_tvalid_i = 1'b0;
  logic          s_axis_tready_o;
  logic [63:0]   s_axis_tdata_i  = '0;  // now_ms[31:0], answer[63:32]
  logic [1:0]    s_axis_tuser_i  = '0;  // kind[1:0]
  logic          m_axis_tvalid_o;
  logic          m_axis_tready_i = 1'b0;
  // status[2:0], current_challenge[34:3], refreshes[66:35],
  // early_refreshes[98:67], longest_interval[130:99], zero[135:131]
  logic [135:0]  m_axis_tdata_o;

  watchdog_tracker tracker;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_idle_pct = 0;
  int              hold_asked    = 0;
  logic [31:0]     clock_ms      = '0;

  window_challenge_watchdog_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: random back-pressure, plus a long hold-off whenever one is asked for.
  initial begin : receiver
    int stall_left;
    int served;
    stall_left = 0;
    served     = 0;
    forever begin
      @(posedge clk_i);
      if (served != hold_asked) begin
        served     = hold_asked;
        stall_left = HoldCycles;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) tracker.match_result(m_axis_tdata_o);
  end

  task automatic send_event(kind_e kind, logic [31:0] now, logic [31:0] answer);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {answer, now};
    s_axis_tuser_i  <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    tracker.log_event(kind, now, answer);
  endtask

  // Drop valid, wait for every owed result, then let the pipeline settle.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_regs(mode_e mode, logic [31:0] win_min);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CfgMode;
    cfg_wdata_i <= {30'd0, mode};
    @(posedge clk_i);
    cfg_addr_i  <= CfgWinMin;
    cfg_wdata_i <= win_min;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.set_reg(CfgMode, {30'd0, mode});
    tracker.set_reg(CfgWinMin, win_min);
  endtask

  function automatic logic [31:0] pick_window();
    case ($urandom_range(5))
      0:       return '0;
      1:       return 32'd1;
      2:       return '1;
      5:       return $urandom();
      default: return $urandom_range(150, 20);
    endcase
  endfunction

  task automatic send_random();
    kind_e       kind;
    logic [31:0] answer;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 6) kind = KIND_START;
    else if (pick < 10) kind = KIND_NONE;
    else if (pick < 50) kind = KIND_REFRESH;
    else kind = KIND_CHAL;
    case ($urandom_range(9))
      0: begin
      end
      1, 2, 3, 4, 5: clock_ms = clock_ms + $urandom_range(200);
      6:             clock_ms = clock_ms + $urandom_range(5000);
      7:             clock_ms = $urandom();
      // land one below, on, or one past the window edge
      default:       clock_ms = tracker.last_time + tracker.win_min + $urandom_range(2) - 1;
    endcase
    pick = $urandom_range(9);
    if (kind == KIND_CHAL && pick < 8) begin
      answer = tracker.challenge ^ MaskKey;
    end else if (kind == KIND_CHAL && pick == 8) begin
      answer = tracker.challenge ^ MaskKey ^ (32'd1 << $urandom_range(31));
    end else begin
      answer = $urandom();
    end
    send_event(kind, clock_ms, answer);
  endtask

  initial begin
    tracker = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: not armed, challenge in plain mode, unused kind, double start, interval wrap.
    send_event(KIND_REFRESH, 32'd0, 32'd0);
    send_event(KIND_CHAL, 32'd10, MaskKey);
    send_event(KIND_NONE, '1, '1);
    send_event(KIND_START, 32'd100, 32'd0);
    send_event(KIND_START, 32'd200, 32'd0);
    send_event(KIND_REFRESH, '1, 32'd0);
    send_event(KIND_REFRESH, 32'd5, 32'd0);
    send_event(KIND_REFRESH, 32'd5, 32'd0);
    drain();
    // Challenge mode: wrong answers, then two good ones, then a plain refresh.
    write_regs(MODE_CHAL, '0);
    send_event(KIND_CHAL, 32'd40, 32'd0);
    send_event(KIND_CHAL, 32'd40, ~(tracker.challenge ^ MaskKey));
    send_event(KIND_CHAL, 32'd50, tracker.challenge ^ MaskKey);
    send_event(KIND_CHAL, 32'd60, tracker.challenge ^ MaskKey);
    send_event(KIND_REFRESH, 32'd70, '1);
    drain();
    // Window mode: one short of the window, exactly on it, challenge refused.
    write_regs(MODE_WINDOW, 32'd100);
    send_event(KIND_REFRESH, 32'd169, 32'd0);
    send_event(KIND_REFRESH, 32'd170, 32'd0);
    send_event(KIND_CHAL, 32'd300, tracker.challenge ^ MaskKey);
    drain();
    write_regs(MODE_WINDOW, '1);
    send_event(KIND_REFRESH, 32'd171, 32'd0);
    send_event(KIND_REFRESH, 32'd169, 32'd0);
    drain();
    // Spare mode acts as plain.
    write_regs(MODE_SPARE, '1);
    send_event(KIND_REFRESH, 32'd170, 32'd0);
    send_event(KIND_CHAL, 32'd180, tracker.challenge ^ MaskKey);
    clock_ms = 32'd200;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 10;
          recv_idle_pct = 76;
        end
        1: begin
          send_idle_pct = 76;
          recv_idle_pct = 10;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int chunk = 0; chunk < 4; chunk++) begin
        drain();
        write_regs(mode_e'((chunk + phase) % 4), pick_window());
        // stall the result side while items keep coming
        if (chunk == 1) hold_asked <= hold_asked + 1;
        repeat (ChunkItems) send_random();
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
